@@ rtl/core/wssm_pkg.sv @@
// shared constants and types for the weekly switch schedule matcher
package wssm_pkg;

    localparam int NUM_ENTRIES = 4;
    localparam int CFG_IDX_W   = $clog2(NUM_ENTRIES + 1);
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] IDX_ONE_SHOT = CFG_IDX_W'(NUM_ENTRIES);

    localparam int EN_BIT     = 23;
    localparam int DAY_HI     = 22;
    localparam int DAY_LO     = 16;
    localparam int ACTION_BIT = 13;
    localparam int HOUR_HI    = 12;
    localparam int HOUR_LO    = 8;
    localparam int MIN_HI     = 7;
    localparam int MIN_LO     = 0;

    localparam logic [11:0] MIN_PER_HOUR = 12'd60;
    localparam logic [5:0]  FIRE_WIN_SEC = 6'd5;
    localparam logic [5:0]  CLEAR_SEC    = 6'd30;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;
    localparam logic [1:0] CMD_BAD  = 2'd3;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             weekday;
        logic [4:0]             hour;
        logic [5:0]             minute;
        logic [5:0]             second;
        logic [1:0]             cmd;
        logic                   active;
        logic                   clear;
        logic [NUM_ENTRIES-1:0] retired;
    } t_tok;

    typedef struct packed {
        logic                  entry_we;
        logic                  os_we;
        logic                  os_val;
        logic [CFG_DATA_W-1:0] word;
    } t_cell_cfg;

endpackage

@@ rtl/core/wssm_sample_if.sv @@
// clock sample channel
interface wssm_sample_if import wssm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;

    modport source (output valid, weekday, hour, minute, second, input ready);
    modport sink   (input valid, weekday, hour, minute, second, output ready);
endinterface

@@ rtl/core/wssm_result_if.sv @@
// result channel
interface wssm_result_if import wssm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             switch_command;
    logic                   schedule_active;
    logic                   hour_energy_clear;
    logic [NUM_ENTRIES-1:0] retired_now;

    modport source (output valid, switch_command, schedule_active, hour_energy_clear,
                    retired_now, input ready);
    modport sink   (input valid, switch_command, schedule_active, hour_energy_clear,
                    retired_now, output ready);
endinterface

@@ rtl/core/wssm_cfg_if.sv @@
// configuration write channel
interface wssm_cfg_if import wssm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/weekly_switch_schedule_matcher_top.sv @@
// top level: chain of entry cells that a sample token walks through
// the token is registered once per cell through NUM_ENTRIES cells, sample to result
// throughput: one sample per cycle while the result is taken or the output is empty
// reset: synchronous active low, clears entries, one-shot mask, retired bits and valids
// configuration writes are always ready; entry writes hit the addressed cell, mask all
module weekly_switch_schedule_matcher_top import wssm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wssm_sample_if.sink   i_sample,
    wssm_cfg_if.sink      i_cfg,
    wssm_result_if.source o_result
);

    t_tok      w_tok [0:NUM_ENTRIES];
    t_cell_cfg w_cfg [0:NUM_ENTRIES-1];
    logic      adv;
    logic      cfg_xfer;

    assign adv            = !w_tok[NUM_ENTRIES].valid || o_result.ready;
    assign i_sample.ready = adv;
    assign i_cfg.ready    = 1'b1;
    assign cfg_xfer       = i_cfg.valid && i_cfg.ready;

    always_comb begin
        w_tok[0].valid   = i_sample.valid;
        w_tok[0].weekday = i_sample.weekday;
        w_tok[0].hour    = i_sample.hour;
        w_tok[0].minute  = i_sample.minute;
        w_tok[0].second  = i_sample.second;
        w_tok[0].cmd     = CMD_NONE;
        w_tok[0].active  = 1'b0;
        w_tok[0].clear   = (i_sample.minute == 6'd0) && (i_sample.second <= CLEAR_SEC);
        w_tok[0].retired = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
            assign w_cfg[g].entry_we = cfg_xfer && (i_cfg.index == CFG_IDX_W'(g));
            assign w_cfg[g].os_we    = cfg_xfer && (i_cfg.index == IDX_ONE_SHOT);
            assign w_cfg[g].os_val   = i_cfg.data[g];
            assign w_cfg[g].word     = i_cfg.data;

            wssm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_cfg   (w_cfg[g]),
                .i_sel   (NUM_ENTRIES'(1) << g),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign o_result.valid             = w_tok[NUM_ENTRIES].valid;
    assign o_result.switch_command    = w_tok[NUM_ENTRIES].cmd;
    assign o_result.schedule_active   = w_tok[NUM_ENTRIES].active;
    assign o_result.hour_energy_clear = w_tok[NUM_ENTRIES].clear;
    assign o_result.retired_now       = w_tok[NUM_ENTRIES].retired;

    a_cmd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.switch_command != CMD_BAD))
        else $error("illegal switch command");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |-> !i_sample.ready)
        else $error("sample taken while result stalled");

    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> w_tok[1].valid)
        else $error("accepted sample lost at first cell");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !w_tok[NUM_ENTRIES-1].valid)
        |=> !o_result.valid)
        else $error("result repeated after transfer");

endmodule

@@ rtl/core/wssm_cell.sv @@
// one schedule entry cell: holds the entry and updates the passing sample token
module wssm_cell import wssm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  t_cell_cfg              i_cfg,
    input  logic [NUM_ENTRIES-1:0] i_sel,
    input  t_tok                   i_tok,
    output t_tok                   o_tok
);

    logic [CFG_DATA_W-1:0] r_word;
    logic                  r_one_shot;
    logic                  r_retired;
    logic                  n_retired;
    t_tok                  r_tok;
    t_tok                  n_tok;

    logic [7:0]  day_vec;
    logic        live;
    logic        day_ok;
    logic [11:0] now;
    logic [11:0] at;
    logic        fire;
    logic        late;
    logic        retire;

    always_comb begin
        day_vec = {r_word[DAY_HI:DAY_LO], 1'b0};
        live    = !r_retired && r_word[EN_BIT];
        day_ok  = day_vec[i_tok.weekday];
        now     = {7'd0, i_tok.hour} * MIN_PER_HOUR + {6'd0, i_tok.minute};
        at      = {7'd0, r_word[HOUR_HI:HOUR_LO]} * MIN_PER_HOUR
                + {4'd0, r_word[MIN_HI:MIN_LO]};
        fire    = live && day_ok && (now == at) && (i_tok.second <= FIRE_WIN_SEC);
        late    = live && day_ok && (now > at);
        retire  = (fire || late) && r_one_shot;

        n_retired = r_retired;
        n_tok     = r_tok;
        if (i_adv) begin
            n_tok = i_tok;
            if (i_tok.valid) begin
                n_retired      = r_retired | retire;
                n_tok.active   = i_tok.active | live;
                n_tok.retired  = i_tok.retired | (i_sel & {NUM_ENTRIES{retire}});
                if (fire) begin
                    n_tok.cmd = r_word[ACTION_BIT] ? CMD_ON : CMD_OFF;
                end
            end
        end
        if (i_cfg.entry_we) begin
            n_retired = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_one_shot <= 1'b0;
            r_retired  <= 1'b0;
            r_tok      <= '0;
        end else begin
            r_tok     <= n_tok;
            r_retired <= n_retired;
            if (i_cfg.entry_we) begin
                r_word <= i_cfg.word;
            end
            if (i_cfg.os_we) begin
                r_one_shot <= i_cfg.os_val;
            end
        end
    end

    assign o_tok = r_tok;

endmodule
